// ----- rtl/prx_pkg.sv -----
// Shared types, constants and coefficient functions for the point rotation block.
package prx_pkg;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 18;
  localparam int COORD_W     = 20;
  localparam int OPER_W      = COORD_W + 1;
  localparam int TURN_W      = 7;
  localparam int COLS_W      = 10;
  localparam int ROWS_W      = 10;
  localparam int PPC_W       = 6;
  localparam int OFFS_W      = 15;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int ANGLE_STEPS = 12;
  localparam int IDX_W       = 4;

  // Reduction of a turn count modulo twelve: bias into a positive range, then
  // a reciprocal multiply gives the quotient and one multiply-subtract the rest.
  localparam int TURN_BIAS   = 6 * ANGLE_STEPS;
  localparam int RECIP_MUL   = 171;
  localparam int RECIP_SHIFT = 11;

  // sqrt(3)/2 scaled by 2^40.
  localparam longint SQRT3_HALF_Q40 = 64'sd952205001410;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURNS_X = 3'd0,
    REG_TURNS_Y = 3'd1,
    REG_TURNS_Z = 3'd2,
    REG_COLS    = 3'd3,
    REG_ROWS    = 3'd4,
    REG_PPC     = 3'd5
  } cfg_reg_t;

  function automatic logic [IDX_W-1:0] angle_idx(logic signed [TURN_W-1:0] t);
    logic [8:0]  u;
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  rem;
    u    = 9'(t) + 9'(TURN_BIAS);
    prod = 16'(u) * 16'(RECIP_MUL);
    q    = 4'(prod >> RECIP_SHIFT);
    rem  = 8'(u) - 8'(q) * 8'(ANGLE_STEPS);
    return rem[IDX_W-1:0];
  endfunction

  // Cosine of step k is the sine of step k plus a quarter turn.
  function automatic logic [IDX_W-1:0] cos_idx(logic [IDX_W-1:0] k);
    return (k >= IDX_W'(ANGLE_STEPS - 3)) ? k - IDX_W'(ANGLE_STEPS - 3) : k + IDX_W'(3);
  endfunction

  function automatic longint coef_r3h(int frac);
    return (SQRT3_HALF_Q40 + (longint'(1) <<< (39 - frac))) >>> (40 - frac);
  endfunction

  function automatic longint sine_q(logic [IDX_W-1:0] k, int frac);
    longint one;
    longint half;
    longint r3h;
    one  = longint'(1) <<< frac;
    half = longint'(1) <<< (frac - 1);
    r3h  = coef_r3h(frac);
    case (k)
      4'd0:    return 0;
      4'd1:    return half;
      4'd2:    return r3h;
      4'd3:    return one;
      4'd4:    return r3h;
      4'd5:    return half;
      4'd6:    return 0;
      4'd7:    return -half;
      4'd8:    return -r3h;
      4'd9:    return -one;
      4'd10:   return -r3h;
      4'd11:   return -half;
      default: return 0;
    endcase
  endfunction

endpackage

// ----- rtl/prx_if.sv -----
// Stream interfaces for input points and rotated result points.
interface prx_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prx_pkg::IN_W-1:0]       x_in;
  logic signed [prx_pkg::IN_W-1:0]       y_in;
  logic signed [prx_pkg::IN_W-1:0]       z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface prx_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prx_pkg::OUT_W-1:0]      x_out;
  logic signed [prx_pkg::OUT_W-1:0]      y_out;
  logic signed [prx_pkg::OUT_W-1:0]      z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

// ----- rtl/point_rotate_xyz_30deg_top.sv -----
// Top level of the three-axis point rotation block with its register file.
//
// Each input beat carries one point (x, y, z) and produces exactly one result
// beat. The point passes through a row of three identical rotation cells,
// about X acting on (y, z), about Y acting on (x, z) and about Z acting on
// (x, y), each turning by its configured count of 30 degree steps. A cell
// whose turn count is nonzero first subtracts the centring offset, half of
// the scaled map height for y and half of the scaled map width for x, and
// never adds it back. Every cell result is truncated toward zero; only the
// final coordinates are saturated to 18 bits. The block takes one point every
// clock cycle while the output is not stalled; a point passes through one input
// register, two stages in each of the three cells and the output register,
// and each cell holds four multipliers so that throughput is never shared.
// All stages advance together whenever the output register is empty or is
// being read, so ready depends only on the output side. Configuration is
// written through a plain write port, by the user only while no point is in
// flight; the block itself does not enforce this. Sine, cosine and offsets
// are derived from the configuration registers into a further register set.
module point_rotate_xyz_30deg_top #(
  parameter int COEF_FRAC_BITS = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [prx_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [prx_pkg::CFG_DATA_W-1:0]     cfg_data,
  prx_in_if.sink                             pt_in,
  prx_out_if.source                          pt_out
);
  import prx_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam coord_t OUT_MAX = coord_t'((1 <<< (OUT_W - 1)) - 1);
  localparam coord_t OUT_MIN = -coord_t'(1 <<< (OUT_W - 1));

  // Configuration registers.
  logic signed [TURN_W-1:0] turns_x, turns_y, turns_z;
  logic [COLS_W-1:0]        map_columns;
  logic [ROWS_W-1:0]        map_rows;
  logic [PPC_W-1:0]         pixels_per_cell;

  // Derived per-cell constants.
  logic signed [COEF_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z_neg;
  logic [OFFS_W-1:0]        off_y_x, off_x_y, off_x_z, off_y_z;
  logic [IDX_W-1:0]         k_x, k_y, k_z;
  logic [15:0]              cols_scaled, rows_scaled;
  logic [OFFS_W-1:0]        half_cols, half_rows;

  // Pipeline.
  logic   adv;
  logic   in_v;
  coord_t in_x, in_y, in_z;
  logic   vx, vy, vz;
  coord_t xa, xb, xc;   // after X cell: y, z, x
  coord_t ya, yb, yc;   // after Y cell: x, z, y
  coord_t za, zb, zc;   // after Z cell: x, y, z

  function automatic logic signed [OUT_W-1:0] sat_out(coord_t v);
    if (v > OUT_MAX) begin
      return OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[OUT_W-1:0];
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      turns_x         <= '0;
      turns_y         <= '0;
      turns_z         <= '0;
      map_columns     <= '0;
      map_rows        <= '0;
      pixels_per_cell <= PPC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TURNS_X: turns_x         <= cfg_data[TURN_W-1:0];
        REG_TURNS_Y: turns_y         <= cfg_data[TURN_W-1:0];
        REG_TURNS_Z: turns_z         <= cfg_data[TURN_W-1:0];
        REG_COLS:    map_columns     <= cfg_data[COLS_W-1:0];
        REG_ROWS:    map_rows        <= cfg_data[ROWS_W-1:0];
        REG_PPC:     pixels_per_cell <= cfg_data[PPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_x         = angle_idx(turns_x);
    k_y         = angle_idx(turns_y);
    k_z         = angle_idx(turns_z);
    cols_scaled = 16'(map_columns) * 16'(pixels_per_cell);
    rows_scaled = 16'(map_rows) * 16'(pixels_per_cell);
    half_cols   = OFFS_W'(cols_scaled >> 1);
    half_rows   = OFFS_W'(rows_scaled >> 1);
  end

  // The Z cell uses the same form as the others with the sine negated.
  always_ff @(posedge clk) begin
    cos_x     <= COEF_W'(sine_q(cos_idx(k_x), COEF_FRAC_BITS));
    sin_x     <= COEF_W'(sine_q(k_x, COEF_FRAC_BITS));
    cos_y     <= COEF_W'(sine_q(cos_idx(k_y), COEF_FRAC_BITS));
    sin_y     <= COEF_W'(sine_q(k_y, COEF_FRAC_BITS));
    cos_z     <= COEF_W'(sine_q(cos_idx(k_z), COEF_FRAC_BITS));
    sin_z_neg <= -COEF_W'(sine_q(k_z, COEF_FRAC_BITS));
    off_y_x   <= (turns_x != '0) ? half_rows : '0;
    off_x_y   <= (turns_y != '0) ? half_cols : '0;
    off_x_z   <= (turns_z != '0) ? half_cols : '0;
    off_y_z   <= (turns_z != '0) ? half_rows : '0;
  end

  // Every stage moves when the output register is free or being emptied.
  assign adv         = !pt_out.valid || pt_out.ready;
  assign pt_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v         <= 1'b0;
      pt_out.valid <= 1'b0;
    end else if (adv) begin
      in_v         <= pt_in.valid;
      pt_out.valid <= vz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_x         <= coord_t'(pt_in.x_in);
      in_y         <= coord_t'(pt_in.y_in);
      in_z         <= coord_t'(pt_in.z_in);
      pt_out.x_out <= sat_out(za);
      pt_out.y_out <= sat_out(zb);
      pt_out.z_out <= sat_out(zc);
    end
  end

  prx_rot_cell #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell_x (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_v),
    .a_in(in_y), .b_in(in_z), .c_in(in_x),
    .off_a(off_y_x), .off_b('0), .cos_q(cos_x), .sin_q(sin_x),
    .out_valid(vx), .a_out(xa), .b_out(xb), .c_out(xc)
  );

  prx_rot_cell #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell_y (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(vx),
    .a_in(xc), .b_in(xb), .c_in(xa),
    .off_a(off_x_y), .off_b('0), .cos_q(cos_y), .sin_q(sin_y),
    .out_valid(vy), .a_out(ya), .b_out(yb), .c_out(yc)
  );

  prx_rot_cell #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell_z (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(vy),
    .a_in(ya), .b_in(yc), .c_in(yb),
    .off_a(off_x_z), .off_b(off_y_z), .cos_q(cos_z), .sin_q(sin_z_neg),
    .out_valid(vz), .a_out(za), .b_out(zb), .c_out(zc)
  );

endmodule

// ----- rtl/prx_rot_cell.sv -----
// One rotation cell: offset, four products, then sums truncated toward zero.
module prx_rot_cell #(
  parameter int COEF_FRAC_BITS = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  prx_pkg::coord_t                     a_in,
  input  prx_pkg::coord_t                     b_in,
  input  prx_pkg::coord_t                     c_in,
  input  logic [prx_pkg::OFFS_W-1:0]          off_a,
  input  logic [prx_pkg::OFFS_W-1:0]          off_b,
  input  logic signed [COEF_FRAC_BITS+1:0]    cos_q,
  input  logic signed [COEF_FRAC_BITS+1:0]    sin_q,
  output logic                                out_valid,
  output prx_pkg::coord_t                     a_out,
  output prx_pkg::coord_t                     b_out,
  output prx_pkg::coord_t                     c_out
);
  import prx_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = OPER_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((longint'(1) <<< COEF_FRAC_BITS) - 1);

  logic signed [OPER_W-1:0] a_off;
  logic signed [OPER_W-1:0] b_off;
  logic signed [PROD_W-1:0] p_ac, p_bs, p_as, p_bc;
  logic                     v1;
  coord_t                   c1;
  logic signed [SUM_W-1:0]  s_a, s_b;
  logic signed [SUM_W-1:0]  t_a, t_b;

  assign a_off = OPER_W'(a_in) - OPER_W'(signed'({1'b0, off_a}));
  assign b_off = OPER_W'(b_in) - OPER_W'(signed'({1'b0, off_b}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ac  <= PROD_W'(a_off) * PROD_W'(cos_q);
      p_bs  <= PROD_W'(b_off) * PROD_W'(sin_q);
      p_as  <= PROD_W'(a_off) * PROD_W'(sin_q);
      p_bc  <= PROD_W'(b_off) * PROD_W'(cos_q);
      c1    <= c_in;
      a_out <= t_a[COORD_W-1:0];
      b_out <= t_b[COORD_W-1:0];
      c_out <= c1;
    end
  end

  // Adding one less than the scale before an arithmetic shift turns the
  // floor of a negative sum into truncation toward zero.
  always_comb begin
    s_a = SUM_W'(p_ac) + SUM_W'(p_bs);
    s_b = SUM_W'(p_bc) - SUM_W'(p_as);
    t_a = (s_a + (s_a[SUM_W-1] ? BIAS : '0)) >>> COEF_FRAC_BITS;
    t_b = (s_b + (s_b[SUM_W-1] ? BIAS : '0)) >>> COEF_FRAC_BITS;
  end

endmodule
